// ----- rtl/http_chunked_body_decoder_top_defines.svh -----
// assertion macros for the chunked body decoder
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HCBD_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: check failed");

// next-cycle implication, checked outside reset
`define HCBD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");

`endif

// ----- rtl/hcbd_pkg.sv -----
// shared types, codes and helpers for the chunked body decoder
package hcbd_pkg;

   localparam int SIZE_BITS = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_SIZE    = 3'd1;
   localparam logic [2:0] PH_SIZE_LF = 3'd2;
   localparam logic [2:0] PH_DATA    = 3'd3;
   localparam logic [2:0] PH_SKIP    = 3'd4;
   localparam logic [2:0] PH_PASS    = 3'd5;
   localparam logic [2:0] PH_DONE    = 3'd6;

   localparam logic [1:0] KIND_BODY = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [1:0] HM_NONE   = 2'd0;
   localparam logic [1:0] HM_CR     = 2'd1;
   localparam logic [1:0] HM_CRLF   = 2'd2;
   localparam logic [1:0] HM_CRLFCR = 2'd3;

   localparam logic [1:0] SKIP_TRAILER = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic done;
   } front_status_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// ----- rtl/hcbd_front.sv -----
// front end: accepts stream bytes, runs the framing parser, queues results
module hcbd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,
   input  logic                        req_valid,
   input  logic [7:0]                  req_byte_in,
   output logic                        req_stall,
   input  hcbd_pkg::fifo_status_type   fifo_status,
   output logic                        push_valid,
   output hcbd_pkg::entry_type         push_entry,
   output hcbd_pkg::front_status_type  front_status
);
   import hcbd_pkg::*;

   logic                 chunked_mode_ff;
   logic [2:0]           phase_ff, phase_in;
   logic [1:0]           header_match_ff, header_match_in;
   logic [SIZE_BITS-1:0] chunk_remaining_ff, chunk_remaining_in;
   logic [SIZE_BITS-1:0] remaining_dec;
   logic [1:0]           skip_count_ff, skip_count_in;
   logic [1:0]           skip_dec;
   logic                 accept;
   logic [4:0]           hex;
   logic                 res_valid;
   entry_type            res;

   assign req_stall = fifo_status.full;
   assign accept    = req_valid && !fifo_status.full;
   assign hex       = hex_decode(req_byte_in);
   assign remaining_dec = chunk_remaining_ff - SIZE_BITS'(1);
   assign skip_dec  = skip_count_ff - 2'd1;

   always_comb begin
      phase_in           = phase_ff;
      header_match_in    = header_match_ff;
      chunk_remaining_in = chunk_remaining_ff;
      skip_count_in      = skip_count_ff;
      res_valid          = 1'b0;
      res.out_byte       = 8'd0;
      res.kind           = KIND_BODY;
      case (phase_ff)
         PH_HEADER: begin
            if (req_byte_in == CH_CR) begin
               header_match_in = (header_match_ff == HM_CRLF) ? HM_CRLFCR : HM_CR;
            end else if (req_byte_in == CH_LF && header_match_ff == HM_CR) begin
               header_match_in = HM_CRLF;
            end else if (req_byte_in == CH_LF && header_match_ff == HM_CRLFCR) begin
               header_match_in    = HM_NONE;
               chunk_remaining_in = '0;
               phase_in           = chunked_mode_ff ? PH_SIZE : PH_PASS;
            end else begin
               header_match_in = HM_NONE;
            end
         end
         PH_PASS: begin
            res_valid    = 1'b1;
            res.out_byte = req_byte_in;
         end
         PH_SIZE: begin
            if (req_byte_in == CH_CR) begin
               phase_in = PH_SIZE_LF;
            end else if (!hex[4] || chunk_remaining_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.kind  = KIND_ERR;
            end else begin
               chunk_remaining_in = {chunk_remaining_ff[SIZE_BITS-5:0], hex[3:0]};
            end
         end
         PH_SIZE_LF: begin
            phase_in  = PH_DONE;
            res_valid = 1'b1;
            if (req_byte_in != CH_LF) begin
               res.kind = KIND_ERR;
            end else if (chunk_remaining_ff == '0) begin
               res.kind = KIND_END;
            end else begin
               phase_in  = PH_DATA;
               res_valid = 1'b0;
            end
         end
         PH_DATA: begin
            chunk_remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               skip_count_in = SKIP_TRAILER;
               phase_in      = PH_SKIP;
            end
            res_valid    = 1'b1;
            res.out_byte = req_byte_in;
         end
         PH_SKIP: begin
            skip_count_in = skip_dec;
            if (skip_dec == 2'd0) begin
               chunk_remaining_in = '0;
               phase_in           = PH_SIZE;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   assign push_valid        = accept && res_valid;
   assign push_entry        = res;
   assign front_status.done = (phase_ff == PH_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff    <= 1'b1;
         phase_ff           <= PH_HEADER;
         header_match_ff    <= HM_NONE;
         chunk_remaining_ff <= '0;
         skip_count_ff      <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            chunked_mode_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff           <= phase_in;
            header_match_ff    <= header_match_in;
            chunk_remaining_ff <= chunk_remaining_in;
            skip_count_ff      <= skip_count_in;
         end
      end
   end

endmodule

// ----- rtl/hcbd_fifo.sv -----
// short result queue between parser front end and output stage
module hcbd_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  hcbd_pkg::entry_type        push_entry,
   input  logic                       pop,
   output hcbd_pkg::entry_type        pop_entry,
   output hcbd_pkg::fifo_status_type  status
);
   import hcbd_pkg::*;

   entry_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_entry    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/hcbd_back.sv -----
// back end: drains the queue into the registered result channel
module hcbd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hcbd_pkg::fifo_status_type  fifo_status,
   input  hcbd_pkg::entry_type        pop_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_out_byte,
   output logic [1:0]                 rsp_kind,
   input  logic                       rsp_stall
);
   import hcbd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff;
   logic [1:0] rsp_kind_ff;

   assign pop = !fifo_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_out_byte_ff <= pop_entry.out_byte;
         rsp_kind_ff     <= pop_entry.kind;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_kind     = rsp_kind_ff;

endmodule

// ----- rtl/http_chunked_body_decoder_top.sv -----
// an accepted byte that yields an item is written into the queue, then into the registered rsp channel
// throughput: one byte per cycle while the queue is not full, limited by the parser state update in the front end
// a four-entry queue lets the front keep accepting while the output stage is stalled
// synchronous active-high reset: header skip phase, chunked mode on, queue empty
// the mode register is sampled when the header's final LF is taken
module http_chunked_body_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   input  logic [7:0] req_byte_in,
   output logic       req_stall,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   input  logic       rsp_stall
);
   import hcbd_pkg::*;

   `include "http_chunked_body_decoder_top_defines.svh"

   fifo_status_type  fifo_status;
   front_status_type front_status;
   entry_type        push_entry;
   entry_type        pop_entry;
   logic             push_valid;
   logic             pop;

   hcbd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_byte_in  (req_byte_in),
      .req_stall    (req_stall),
      .fifo_status  (fifo_status),
      .push_valid   (push_valid),
      .push_entry   (push_entry),
      .front_status (front_status)
   );

   hcbd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (fifo_status)
   );

   hcbd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .fifo_status  (fifo_status),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_stall    (rsp_stall)
   );

   `HCBD_ASSERT_NOW(a_no_push_when_full, clock, reset, fifo_status.full, !push_valid)
   `HCBD_ASSERT_NOW(a_no_item_after_done, clock, reset, front_status.done, !push_valid)
   `HCBD_ASSERT_NOW(a_marker_zero_byte, clock, reset, rsp_valid && rsp_kind != KIND_BODY, rsp_out_byte == 8'd0)
   `HCBD_ASSERT_NEXT(a_terminal_sticks, clock, reset, push_valid && push_entry.kind != KIND_BODY, front_status.done)

endmodule

// ----- test/http_chunked_body_decoder_checker.sv -----
// checker for the chunked body decoder: tracks the byte stream, predicts output items, compares
module http_chunked_body_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   input  logic [7:0] req_byte_in,
   input  logic       req_stall,
   input  logic       rsp_valid,
   input  logic [7:0] rsp_out_byte,
   input  logic [1:0] rsp_kind,
   input  logic       rsp_stall,
   output int         mismatches,
   output int         awaited,
   output int         bytes_taken,
   output int         items_seen,
   output int         ends_seen,
   output int         errors_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import hcbd_pkg::*;

   logic                 mode_q;
   logic [2:0]           stage;
   logic [1:0]           crlf_seen;
   logic [SIZE_BITS-1:0] chunk_left;
   logic [1:0]           skip_left;
   entry_type            decoded_q[$];

   task automatic report(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // {is digit, value}
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      return 5'd0;
   endfunction

   task automatic expect_item(input logic [7:0] value, input logic [1:0] kind);
      entry_type e;
      e.out_byte = value;
      e.kind = kind;
      decoded_q.push_back(e);
   endtask

   task automatic abort_stream();
      stage = PH_DONE;
      expect_item(8'h00, KIND_ERR);
   endtask

   task automatic decode_byte(input logic [7:0] b);
      logic [4:0] dig;
      dig = digit_of(b);
      case (stage)
         PH_HEADER: begin
            if (b == CH_CR) begin
               crlf_seen = (crlf_seen == HM_CRLF) ? HM_CRLFCR : HM_CR;
            end else if (b == CH_LF && crlf_seen == HM_CR) begin
               crlf_seen = HM_CRLF;
            end else if (b == CH_LF && crlf_seen == HM_CRLFCR) begin
               crlf_seen = HM_NONE;
               chunk_left = '0;
               stage = mode_q ? PH_SIZE : PH_PASS;
            end else begin
               crlf_seen = HM_NONE;
            end
         end
         PH_PASS: expect_item(b, KIND_BODY);
         PH_SIZE: begin
            if (b == CH_CR) begin
               stage = PH_SIZE_LF;
            end else if (!dig[4] || chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
               abort_stream();
            end else begin
               chunk_left = {chunk_left[SIZE_BITS-5:0], dig[3:0]};
            end
         end
         PH_SIZE_LF: begin
            if (b != CH_LF) begin
               abort_stream();
            end else if (chunk_left == '0) begin
               stage = PH_DONE;
               expect_item(8'h00, KIND_END);
            end else begin
               stage = PH_DATA;
            end
         end
         PH_DATA: begin
            chunk_left = chunk_left - SIZE_BITS'(1);
            if (chunk_left == '0) begin
               skip_left = SKIP_TRAILER;
               stage = PH_SKIP;
            end
            expect_item(b, KIND_BODY);
         end
         PH_SKIP: begin
            skip_left = skip_left - 2'd1;
            if (skip_left == 2'd0) begin
               chunk_left = '0;
               stage = PH_SIZE;
            end
         end
         default: stage = PH_DONE;
      endcase
   endtask

   always @(posedge clock) begin : watch
      entry_type want;
      if (reset) begin
         mode_q = 1'b1;
         stage = PH_HEADER;
         crlf_seen = HM_NONE;
         chunk_left = '0;
         skip_left = 2'd0;
         decoded_q.delete();
         mismatches = 0;
         bytes_taken = 0;
         items_seen = 0;
         ends_seen = 0;
         errors_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            items_seen++;
            if (rsp_kind == KIND_END) ends_seen++;
            if (rsp_kind == KIND_ERR) errors_seen++;
            if (decoded_q.size() == 0) begin
               report($sformatf("unexpected item byte %02h kind %0d",
                                rsp_out_byte, rsp_kind));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  report($sformatf("out_byte %02h, expected %02h", rsp_out_byte, want.out_byte));
               end
               if (rsp_kind !== want.kind) begin
                  report($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            decode_byte(req_byte_in);
         end
         if (csr_wr_en) begin
            mode_q = csr_wr_data;
         end
      end
      awaited = decoded_q.size();
   end

endmodule

// ----- test/http_chunked_body_decoder_top_test.sv -----
// testbench top for the chunked body decoder: clock, reset, byte stream, stalls and verdict
module http_chunked_body_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hcbd_pkg::*;

   localparam int ITEM_TARGET = 1050;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum {
      CLOSE_NONE,
      CLOSE_END,
      CLOSE_EMPTY,
      CLOSE_BAD_CHAR,
      CLOSE_NO_LF,
      CLOSE_OVERFLOW
   } closing_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_wr_data;
   logic       req_valid;
   logic [7:0] req_byte_in;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_stall;

   int          mismatches;
   int          awaited;
   int          bytes_taken;
   int          items_seen;
   int          ends_seen;
   int          errors_seen;
   int          clock_ticks;
   int          bytes_sent;
   bit          calm;
   bit          chunked_body;
   closing_type closing;

   http_chunked_body_decoder_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_byte_in  (req_byte_in),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_stall    (rsp_stall)
   );

   http_chunked_body_decoder_checker i_check (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_byte_in  (req_byte_in),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_stall    (rsp_stall),
      .mismatches   (mismatches),
      .awaited      (awaited),
      .bytes_taken  (bytes_taken),
      .items_seen   (items_seen),
      .ends_seen    (ends_seen),
      .errors_seen  (errors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      clock_ticks <= clock_ticks + 1;
   end

   initial begin
      wait (clock_ticks >= CYCLE_LIMIT);
      $display("run did not drain within %0d cycles", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 4'd10) return 8'("0") + v;
      return (upper ? 8'("A") : 8'("a")) + v - 8'd10;
   endfunction

   // output side stall pattern, with quiet stretches
   initial begin
      int stall_len;
      int open_len;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 11) == 0) begin
            stall_len = 0;
            open_len = $urandom_range(30, 150);
         end else begin
            stall_len = pick_gap();
            open_len = $urandom_range(1, 6);
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (open_len) @(negedge clock);
      end
   end

   task automatic put_byte(input logic [7:0] value);
      int gap;
      gap = calm ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= value;
      bytes_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(input logic value);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic put_size(input int unsigned n, input int zeros);
      int digits;
      int i;
      digits = 1;
      while (digits < 8 && (n >> (4 * digits)) != 0) digits++;
      repeat (zeros) put_byte("0");
      for (i = digits - 1; i >= 0; i--) begin
         put_byte(hex_char(4'(n >> (4 * i)), 1'($urandom_range(0, 1))));
      end
      put_byte(CH_CR);
      put_byte(CH_LF);
   endtask

   task automatic put_chunk(input int unsigned n, input int zeros);
      put_size(n, zeros);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) begin
         put_byte(CH_CR);
         put_byte(CH_LF);
      end else begin
         repeat (2) put_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [7:0] b;
      int         n;
      logic [7:0] near_miss [16];
      near_miss = '{CH_CR, CH_CR, CH_LF, "x", CH_CR, CH_LF, CH_CR, "y",
                    CH_CR, CH_LF, CH_CR, CH_CR, CH_LF, 8'h00, 8'hFF, CH_LF};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_byte_in = 8'h00;
      calm = 1'b0;
      bytes_sent = 0;
      closing = CLOSE_NONE;
      chunked_body = ($urandom_range(0, 3) != 0);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mode(!chunked_body);
      // header lines without CR inside, then sequences that nearly end the header
      put_byte("H");
      repeat ($urandom_range(1, 3)) begin
         put_byte(CH_CR);
         put_byte(CH_LF);
         repeat ($urandom_range(1, 12)) begin
            b = 8'($urandom_range(0, 254));
            put_byte(b >= CH_CR ? b + 8'd1 : b);
         end
      end
      write_mode(1'($urandom_range(0, 1)));
      foreach (near_miss[i]) put_byte(near_miss[i]);
      write_mode(chunked_body);
      put_byte(CH_CR);
      put_byte(CH_LF);
      put_byte(CH_CR);
      put_byte(CH_LF);

      if (chunked_body) begin
         put_size(1, 0);
         put_byte(8'h00);
         put_byte(CH_CR);
         put_byte(CH_LF);
         put_size(2, 1);
         put_byte(8'hFF);
         put_byte(CH_LF);
         put_byte("x");
         put_byte(CH_CR);
         // mode is latched at the end of the header, this must not matter
         write_mode(1'b0);
         put_chunk(28, 0);
         while (bytes_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 11) == 0) write_mode(1'($urandom_range(0, 1)));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            put_chunk(n, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
         end
         calm = 1'b0;
         closing = closing_type'($urandom_range(CLOSE_END, CLOSE_OVERFLOW));
         case (closing)
            CLOSE_END: begin
               repeat ($urandom_range(1, 3)) put_byte("0");
               put_byte(CH_CR);
               put_byte(CH_LF);
            end
            CLOSE_EMPTY: begin
               put_byte(CH_CR);
               put_byte(CH_LF);
            end
            CLOSE_BAD_CHAR: begin
               repeat ($urandom_range(0, 2)) begin
                  put_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
               end
               case ($urandom_range(0, 4))
                  0: put_byte(";");
                  1: put_byte(CH_LF);
                  2: put_byte(8'($urandom_range(8'h67, 8'hFF)));
                  3: put_byte(8'($urandom_range(8'h47, 8'h60)));
                  default: put_byte(8'($urandom_range(8'h0E, 8'h2F)));
               endcase
            end
            CLOSE_NO_LF: begin
               put_byte("5");
               put_byte(CH_CR);
               b = 8'($urandom_range(0, 254));
               put_byte(b >= CH_LF ? b + 8'd1 : b);
            end
            CLOSE_OVERFLOW: begin
               put_byte("0");
               put_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
               repeat (SIZE_BITS / 4) begin
                  put_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
               end
            end
            default: ;
         endcase
         // trailer after the stream is closed, all ignored
         repeat (16) put_byte(8'($urandom_range(0, 255)));
      end else begin
         put_byte(8'h00);
         put_byte(8'hFF);
         put_byte(CH_CR);
         put_byte(CH_LF);
         put_byte(CH_CR);
         put_byte(CH_LF);
         write_mode(1'b1);
         while (bytes_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 11) == 0) write_mode(1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 40)) put_byte(8'($urandom_range(0, 255)));
         end
         calm = 1'b0;
      end

      settle();
      repeat (10) @(negedge clock);
      $display("%0d bytes taken, %0d items checked (%0d end, %0d error), %0d mismatches",
               bytes_taken, items_seen, ends_seen, errors_seen, mismatches);
      $display("body coding %s, stream closed by %s",
               chunked_body ? "chunked" : "pass-through", closing.name());
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
